[rtl/rmsvad_pkg.sv]
// Shared types and constants for the RMS voice activity detector.
// No dependencies; every module of the block imports this package.
package rmsvad_pkg;

    // Payload and register widths
    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 31;
    localparam int THRESH_W    = 31;
    localparam int HOLD_W      = 20;
    localparam int RUN_W       = 24;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 2;

    // Saturation value of the loud and quiet run counters
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Register values after reset
    localparam logic [THRESH_W-1:0] LEVEL_THRESHOLD_SQ_RST = THRESH_W'(107374);
    localparam logic [HOLD_W-1:0]   ON_HOLD_SAMPLES_RST    = HOLD_W'(4800);
    localparam logic [HOLD_W-1:0]   OFF_HOLD_SAMPLES_RST   = HOLD_W'(14400);

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_THRESHOLD_SQ = 2'd0,
        REG_ON_HOLD_SAMPLES    = 2'd1,
        REG_OFF_HOLD_SAMPLES   = 2'd2
    } cfg_reg_t;

    // Configuration as seen by the decision logic
    typedef struct packed {
        logic [THRESH_W-1:0] level_threshold_sq;
        logic [HOLD_W-1:0]   on_hold_samples;
        logic [HOLD_W-1:0]   off_hold_samples;
    } vad_cfg_t;

endpackage

[rtl/rms_voice_activity_hysteresis.sv]
// RMS voice activity detector with hysteresis: top level and configuration registers.
// Depends on rmsvad_pkg, rmsvad_accum and rmsvad_decide.
//
// The block takes one signed 16-bit sample per clock, sustained, with no
// gaps between bursts; the open-burst accumulator adds one squared sample per
// cycle and sets that rate. A burst closes on burst_end or at its MAX_BURST-th
// sample and is called loud when its sum of squares exceeds the threshold
// register times its length. The talking transfer for a burst that flips the
// state appears on the output once its last sample has passed through the
// input, square, burst, product and compare registers and then the output
// register. While a result waits, samples keep flowing until three more
// closed bursts have queued behind it in the compare, product and burst
// registers; after that the square and input registers fill and the input
// stalls until the result is taken. Configuration writes take effect at once
// and belong in idle periods.
module rms_voice_activity_hysteresis
    import rmsvad_pkg::*;
#(
    parameter int MAX_BURST = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       burst_end,
    input  logic                       paused,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       talking
);

    localparam int CW = $clog2(MAX_BURST + 1);
    localparam int EW = 30 + CW;

    vad_cfg_t       cfg_reg;
    logic           burst_valid;
    logic           burst_ready;
    logic [EW-1:0]  burst_energy;
    logic [CW-1:0]  burst_len;
    logic           burst_paused;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold_sq <= LEVEL_THRESHOLD_SQ_RST;
            cfg_reg.on_hold_samples    <= ON_HOLD_SAMPLES_RST;
            cfg_reg.off_hold_samples   <= OFF_HOLD_SAMPLES_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEVEL_THRESHOLD_SQ:
                begin
                    cfg_reg.level_threshold_sq <= cfg_wdata[THRESH_W-1:0];
                end
                REG_ON_HOLD_SAMPLES:
                begin
                    cfg_reg.on_hold_samples <= cfg_wdata[HOLD_W-1:0];
                end
                REG_OFF_HOLD_SAMPLES:
                begin
                    cfg_reg.off_hold_samples <= cfg_wdata[HOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sample side: squaring and burst accumulation
    rmsvad_accum #(
        .MAX_BURST (MAX_BURST)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .burst_end    (burst_end),
        .paused       (paused),
        .burst_valid  (burst_valid),
        .burst_ready  (burst_ready),
        .burst_energy (burst_energy),
        .burst_len    (burst_len),
        .burst_paused (burst_paused)
    );

    // Burst side: loudness decision and hysteresis
    rmsvad_decide #(
        .MAX_BURST (MAX_BURST)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .burst_valid  (burst_valid),
        .burst_ready  (burst_ready),
        .burst_energy (burst_energy),
        .burst_len    (burst_len),
        .burst_paused (burst_paused),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .talking      (talking)
    );

endmodule

[rtl/rmsvad_accum.sv]
// Sample side of the detector: input register, squaring stage and burst accumulators.
// Depends on rmsvad_pkg. Emits one record (energy, length, paused) per closed burst.
module rmsvad_accum
    import rmsvad_pkg::*;
#(
    parameter int MAX_BURST = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                    burst_end,
    input  logic                    paused,
    output logic                    burst_valid,
    input  logic                    burst_ready,
    output logic [30+$clog2(MAX_BURST+1)-1:0] burst_energy,
    output logic [$clog2(MAX_BURST+1)-1:0]    burst_len,
    output logic                    burst_paused
);

    localparam int CW = $clog2(MAX_BURST + 1);
    localparam int EW = 30 + CW;

    // Input register
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic                s1_paused_reg;

    // Squared sample register
    logic                s2_valid_reg;
    logic [SQ_W-1:0]     s2_sq_reg;
    logic                s2_last_reg;
    logic                s2_paused_reg;

    // Open burst accumulators
    logic [EW-1:0]       acc_energy_reg;
    logic [CW-1:0]       acc_count_reg;

    // Closed burst record
    logic                burst_valid_reg;
    logic [EW-1:0]       burst_energy_reg;
    logic [CW-1:0]       burst_len_reg;
    logic                burst_paused_reg;

    logic                out_free;
    logic                s2_ready;
    logic                s1_ready;
    logic                s1_fire;
    logic                s2_fire;
    logic [SAMPLE_W:0]   sample_ext;
    logic [SAMPLE_W:0]   sample_neg;
    logic [SAMPLE_W-1:0] mag;
    logic [2*SAMPLE_W-1:0] sq_full;
    logic [EW-1:0]       energy_inc;
    logic [CW-1:0]       count_inc;
    logic                close;

    // Each stage moves when the one after it is empty or moving on.
    assign out_free = !burst_valid_reg || burst_ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s2_fire  = s2_valid_reg && out_free;

    // Magnitude of the sample; the most negative value gives 2^15 exactly.
    assign sample_ext = {s1_sample_reg[SAMPLE_W-1], s1_sample_reg};
    assign sample_neg = (SAMPLE_W+1)'(0) - sample_ext;
    assign mag        = sample_ext[SAMPLE_W] ? sample_neg[SAMPLE_W-1:0]
                                             : sample_ext[SAMPLE_W-1:0];
    assign sq_full    = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};

    // Accumulate and detect the end of a burst, forced at MAX_BURST samples.
    assign energy_inc = acc_energy_reg + EW'(s2_sq_reg);
    assign count_inc  = acc_count_reg + CW'(1);
    assign close      = s2_last_reg || (count_inc == CW'(MAX_BURST));

    // Valid flags and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            burst_valid_reg <= 1'b0;
            acc_energy_reg  <= '0;
            acc_count_reg   <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_fire;
            end
            if (out_free)
            begin
                burst_valid_reg <= s2_fire && close;
            end
            if (s2_fire)
            begin
                if (close)
                begin
                    acc_energy_reg <= '0;
                    acc_count_reg  <= '0;
                end
                else
                begin
                    acc_energy_reg <= energy_inc;
                    acc_count_reg  <= count_inc;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= burst_end;
            s1_paused_reg <= paused;
        end
        if (s1_fire)
        begin
            s2_sq_reg     <= sq_full[SQ_W-1:0];
            s2_last_reg   <= s1_last_reg;
            s2_paused_reg <= s1_paused_reg;
        end
        if (s2_fire && close)
        begin
            burst_energy_reg <= energy_inc;
            burst_len_reg    <= count_inc;
            burst_paused_reg <= s2_paused_reg;
        end
    end

    assign burst_valid  = burst_valid_reg;
    assign burst_energy = burst_energy_reg;
    assign burst_len    = burst_len_reg;
    assign burst_paused = burst_paused_reg;

`ifndef NO_ASSERTIONS
    // An open burst never holds MAX_BURST samples; that sample closes it.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_count_reg < CW'(MAX_BURST))
        else $error("burst counter reached MAX_BURST");

    // The energy and count accumulators are cleared together.
    a_empty_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_count_reg == '0) |-> (acc_energy_reg == '0))
        else $error("energy left over in an empty burst");

    // A closed burst always holds at least one sample.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (burst_len_reg != '0))
        else $error("closed burst of zero length");
`endif

endmodule

[rtl/rmsvad_decide.sv]
// Burst side of the detector: threshold product, loudness compare, hysteresis runs.
// Depends on rmsvad_pkg. Produces one talking transfer per state change.
module rmsvad_decide
    import rmsvad_pkg::*;
#(
    parameter int MAX_BURST = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  vad_cfg_t                cfg,
    input  logic                    burst_valid,
    output logic                    burst_ready,
    input  logic [30+$clog2(MAX_BURST+1)-1:0] burst_energy,
    input  logic [$clog2(MAX_BURST+1)-1:0]    burst_len,
    input  logic                    burst_paused,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    talking
);

    localparam int CW = $clog2(MAX_BURST + 1);
    localparam int EW = 30 + CW;
    localparam int PW = THRESH_W + CW;

    // Product stage
    logic           p_valid_reg;
    logic [PW-1:0]  p_prod_reg;
    logic [EW-1:0]  p_energy_reg;
    logic [CW-1:0]  p_len_reg;
    logic           p_paused_reg;

    // Loudness stage
    logic           l_valid_reg;
    logic           l_loud_reg;
    logic [CW-1:0]  l_len_reg;
    logic           l_paused_reg;

    // Hysteresis state and result register
    logic              talking_state_reg;
    logic              talking_state_next;
    logic [RUN_W-1:0]  loud_run_reg;
    logic [RUN_W-1:0]  loud_run_next;
    logic [RUN_W-1:0]  quiet_run_reg;
    logic [RUN_W-1:0]  quiet_run_next;
    logic              out_valid_reg;
    logic              talking_reg;

    logic              out_free;
    logic              l_ready;
    logic              p_ready;
    logic              p_fire;
    logic              l_fire;
    logic [PW-1:0]     prod;
    logic              loud;
    logic [RUN_W:0]    loud_sum;
    logic [RUN_W:0]    quiet_sum;
    logic [RUN_W-1:0]  loud_sat;
    logic [RUN_W-1:0]  quiet_sat;
    logic              emit;

    // Stage handshakes
    assign out_free    = !out_valid_reg || out_ready;
    assign l_ready     = !l_valid_reg || out_free;
    assign p_ready     = !p_valid_reg || l_ready;
    assign burst_ready = p_ready;
    assign p_fire      = p_valid_reg && l_ready;
    assign l_fire      = l_valid_reg && out_free;

    // Threshold times burst length stands in for the mean.
    assign prod = PW'(cfg.level_threshold_sq) * PW'(burst_len);
    assign loud = PW'(p_energy_reg) > p_prod_reg;

    // Saturating run sums
    assign loud_sum  = {1'b0, loud_run_reg} + (RUN_W+1)'(l_len_reg);
    assign quiet_sum = {1'b0, quiet_run_reg} + (RUN_W+1)'(l_len_reg);
    assign loud_sat  = loud_sum[RUN_W] ? RUN_MAX : loud_sum[RUN_W-1:0];
    assign quiet_sat = quiet_sum[RUN_W] ? RUN_MAX : quiet_sum[RUN_W-1:0];

    // Run update and talking decision for one closed burst
    always_comb
    begin
        loud_run_next      = loud_run_reg;
        quiet_run_next     = quiet_run_reg;
        talking_state_next = talking_state_reg;
        emit               = 1'b0;
        if (l_fire && !l_paused_reg)
        begin
            if (l_loud_reg)
            begin
                loud_run_next  = loud_sat;
                quiet_run_next = '0;
                if (!talking_state_reg && (loud_sat >= RUN_W'(cfg.on_hold_samples)))
                begin
                    talking_state_next = 1'b1;
                    emit               = 1'b1;
                end
            end
            else
            begin
                quiet_run_next = quiet_sat;
                loud_run_next  = '0;
                if (talking_state_reg && (quiet_sat >= RUN_W'(cfg.off_hold_samples)))
                begin
                    talking_state_next = 1'b0;
                    emit               = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg       <= 1'b0;
            l_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            talking_state_reg <= 1'b0;
            loud_run_reg      <= '0;
            quiet_run_reg     <= '0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= burst_valid;
            end
            if (l_ready)
            begin
                l_valid_reg <= p_fire;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
            talking_state_reg <= talking_state_next;
            loud_run_reg      <= loud_run_next;
            quiet_run_reg     <= quiet_run_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (p_ready && burst_valid)
        begin
            p_prod_reg   <= prod;
            p_energy_reg <= burst_energy;
            p_len_reg    <= burst_len;
            p_paused_reg <= burst_paused;
        end
        if (p_fire)
        begin
            l_loud_reg   <= loud;
            l_len_reg    <= p_len_reg;
            l_paused_reg <= p_paused_reg;
        end
        if (emit)
        begin
            talking_reg <= talking_state_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign talking   = talking_reg;

`ifndef NO_ASSERTIONS
    // At most one of the two runs is nonzero.
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (loud_run_reg == '0) || (quiet_run_reg == '0))
        else $error("loud and quiet runs both active");

    // A pending result always shows the current talking state.
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (talking_reg == talking_state_reg))
        else $error("pending result differs from talking state");

    // The talking state only changes together with a new result.
    a_flip_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (talking_state_reg != $past(talking_state_reg)) |-> out_valid_reg)
        else $error("talking state changed without a result");
`endif

endmodule
